// ----- rtl/core/pointwise_program_interpreter_unit_macros.svh -----
// Assertion macros for the pointwise program interpreter checker.
// Included by the checker file; no other dependencies.
`ifndef POINTWISE_PROGRAM_INTERPRETER_UNIT_MACROS_SVH
`define POINTWISE_PROGRAM_INTERPRETER_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PPI_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ppi same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define PPI_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ppi next-cycle check failed");

`endif

// ----- rtl/core/ppi_pkg.sv -----
// Package for the pointwise program interpreter: op and error codes, types,
// saturation helper and the sigmoid table built at elaboration. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ppi_pkg;

  localparam logic [3:0] OP_LOAD    = 4'd0;
  localparam logic [3:0] OP_CONST   = 4'd1;
  localparam logic [3:0] OP_ADD     = 4'd2;
  localparam logic [3:0] OP_MUL     = 4'd3;
  localparam logic [3:0] OP_RELU    = 4'd4;
  localparam logic [3:0] OP_SILU    = 4'd5;
  localparam logic [3:0] OP_NEG     = 4'd6;
  localparam logic [3:0] OP_SCALE   = 4'd7;
  localparam logic [3:0] OP_SIGMOID = 4'd8;

  localparam logic [1:0] ERR_OK   = 2'd0;
  localparam logic [1:0] ERR_LOAD = 2'd1;
  localparam logic [1:0] ERR_OP   = 2'd2;

  localparam logic       CFG_NODE_COUNT  = 1'b0;
  localparam logic       CFG_INPUT_COUNT = 1'b1;

  localparam int MAX_INPUTS = 3;
  localparam int SIG_SIZE = 256;
  localparam logic [63:0] INV_E_Q32 = 64'd1580030169;

  typedef logic signed [31:0] q16_t;
  typedef q16_t sig_table_t [SIG_SIZE];

  typedef struct packed {
    logic [1:0] input_sel;
    logic [3:0] src_b;
    logic [3:0] src_a;
    logic [3:0] op;
    q16_t       alpha;
    q16_t       cst;
  } node_word_t;

  typedef struct packed {
    logic [3:0] op;
    logic [1:0] err;
    q16_t       a;
    q16_t       b;
    q16_t       alpha;
    q16_t       cst;
    q16_t       ldv;
  } exec_req_t;

  typedef struct packed {
    logic [1:0] err;
    q16_t       value;
  } exec_rsp_t;

  function automatic q16_t sat32(input logic signed [63:0] v);
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic logic [7:0] sig_index(input q16_t x);
    logic signed [32:0] t;
    t = 33'(x) + 33'sd524288;
    if (x < -32'sd524288) begin
      return 8'd0;
    end else if (x >= 32'sd524288) begin
      return 8'd255;
    end
    return t[19:12];
  endfunction

  function automatic longint unsigned udiv64(input longint unsigned num,
                                             input longint unsigned den);
    longint unsigned q;
    longint unsigned r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], num[i]};
      if (r >= den) begin
        r = r - den;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic q16_t sigmoid_exact(input longint xq);
    longint unsigned t;
    longint unsigned whole;
    longint unsigned f;
    longint unsigned term;
    longint unsigned sum;
    longint unsigned e;
    longint unsigned s;
    longint unsigned den;
    t = (xq < 0) ? longint'(-xq) : longint'(xq);
    whole = t >> 16;
    f = (t & 64'hFFFF) << 16;
    term = 64'd1 << 32;
    sum = term;
    for (int i = 1; i <= 24; i++) begin
      term = udiv64((term * f) >> 32, 64'(i));
      if (i % 2 == 1) sum = sum - term;
      else sum = sum + term;
    end
    e = sum;
    for (longint unsigned i = 0; i < whole; i++) begin
      e = (e * INV_E_Q32) >> 32;
    end
    den = (64'd1 << 32) + e;
    s = udiv64((64'd1 << 48) + (den >> 1), den);
    if (xq < 0) return 32'(64'd65536 - s);
    return 32'(s);
  endfunction

  function automatic sig_table_t build_sig_table();
    sig_table_t tab;
    longint xs;
    for (int k = 0; k < SIG_SIZE; k++) begin
      xs = -(longint'(8) << 16) + ((2 * longint'(k) + 1) * (longint'(8) << 16)) / SIG_SIZE;
      tab[k] = sigmoid_exact(xs);
    end
    return tab;
  endfunction

  localparam sig_table_t SIG_TABLE = build_sig_table();

endpackage
`default_nettype wire

// ----- rtl/core/ppi_if.sv -----
// Valid/ready channel interfaces for the pointwise program interpreter.
// Depends on ppi_pkg for the Q16.16 type.
`timescale 1ns / 1ps
`default_nettype none
interface ppi_in_if import ppi_pkg::*;;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [3:0] node_index;
  logic [3:0] node_op;
  logic [3:0] node_src_a;
  logic [3:0] node_src_b;
  logic [1:0] node_input;
  q16_t       node_alpha;
  q16_t       node_const;
  q16_t       in_value0;
  q16_t       in_value1;
  q16_t       in_value2;
  logic       last_element;
  modport source (output valid, mode, node_index, node_op, node_src_a, node_src_b,
    node_input, node_alpha, node_const, in_value0, in_value1, in_value2,
    last_element, input ready);
  modport sink (input valid, mode, node_index, node_op, node_src_a, node_src_b,
    node_input, node_alpha, node_const, in_value0, in_value1, in_value2,
    last_element, output ready);
endinterface

interface ppi_out_if import ppi_pkg::*;;
  logic       valid;
  logic       ready;
  q16_t       out_value;
  logic [1:0] error_code;
  logic       out_last;
  modport source (output valid, out_value, error_code, out_last, input ready);
  modport sink (input valid, out_value, error_code, out_last, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/pointwise_program_interpreter_unit.sv -----
// Pointwise program interpreter top level: node sequencer, node and scratch
// memories, output register. Depends on ppi_pkg, ppi_if, ppi_ram, ppi_exec.
//
// Channel  Dir  Handshake     Carries
// in_ch    in   valid/ready   node write (mode 0) or element (mode 1)
// out_ch   out  valid/ready   out_value, error_code, out_last
// cfg      in   cfg_we        node_count (index 0), input_count (index 1)
//
// An element runs its nodes one after another: each node fetches its word from the
// node memory, reads its two sources one after the other from the scratch memory,
// passes three arithmetic stages and writes back.
// Reset sets node_count and input_count to one and marks all node and scratch entries invalid, so they read as zero.
// A result waiting on out_ch holds the sequencer only at the end of the next element.
`timescale 1ns / 1ps
`default_nettype none
module pointwise_program_interpreter_unit import ppi_pkg::*; #(
  parameter int MAX_NODES = 16
) (
  input  wire logic       clk,
  input  wire logic       rst,
  ppi_in_if.sink          in_ch,
  ppi_out_if.source       out_ch,
  input  wire logic       cfg_we,
  input  wire logic       cfg_index,
  input  wire logic [4:0] cfg_data
);
  localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_FETCH = 4'd1;
  localparam logic [3:0] ST_READ  = 4'd2;
  localparam logic [3:0] ST_READB = 4'd3;
  localparam logic [3:0] ST_EXEC  = 4'd4;
  localparam logic [3:0] ST_MUL1  = 4'd5;
  localparam logic [3:0] ST_MUL2  = 4'd6;
  localparam logic [3:0] ST_WB    = 4'd7;
  localparam logic [3:0] ST_DONE  = 4'd8;

  logic [3:0]           state;
  logic [4:0]           node_count;
  logic [1:0]           input_count;
  logic [AW-1:0]        step;
  logic [AW-1:0]        last_node;
  logic [MAX_NODES-1:0] node_vld;
  logic [MAX_NODES-1:0] scr_vld;
  logic                 node_ok;
  logic                 a_ok;
  logic                 b_ok;
  node_word_t           nd;
  node_word_t           node_q;
  node_word_t           node_wd;
  q16_t                 val0;
  q16_t                 val1;
  q16_t                 val2;
  logic                 last_flag;
  logic [AW-1:0]        scr_raddr;
  q16_t                 scr_q;
  q16_t                 qa;
  exec_req_t            req;
  exec_rsp_t            rsp;
  q16_t                 res_val;
  logic [1:0]           res_err;
  logic                 out_valid;
  q16_t                 out_value;
  logic [1:0]           out_err;
  logic                 out_last;
  logic                 accept;
  logic                 node_we;
  logic                 scr_we;
  logic                 fin;
  logic                 out_free;

  assign accept   = in_ch.valid && in_ch.ready;
  assign node_we  = accept && !in_ch.mode && (in_ch.node_index < MAX_NODES);
  assign scr_we   = (state == ST_WB) && (rsp.err == ERR_OK);
  assign out_free = !out_valid || out_ch.ready;
  assign fin = out_free && ((state == ST_DONE) || ((state == ST_WB) &&
               ((rsp.err != ERR_OK) || (step == last_node))));

  always_comb begin
    if (node_count == 5'd0) begin
      last_node = '0;
    end else if (node_count > MAX_NODES) begin
      last_node = AW'(MAX_NODES - 1);
    end else begin
      last_node = AW'(node_count - 5'd1);
    end
  end

  assign node_wd = '{input_sel: in_ch.node_input, src_b: in_ch.node_src_b,
                     src_a: in_ch.node_src_a, op: in_ch.node_op,
                     alpha: in_ch.node_alpha, cst: in_ch.node_const};

  ppi_ram #(.WIDTH($bits(node_word_t)), .DEPTH(MAX_NODES)) u_node_ram (
    .clk(clk), .we(node_we), .waddr(AW'(in_ch.node_index)), .wdata(node_wd),
    .raddr(step), .rdata(node_q)
  );

  assign scr_raddr = (state == ST_READ) ? AW'(nd.src_a) : AW'(nd.src_b);

  ppi_ram #(.WIDTH(32), .DEPTH(MAX_NODES)) u_scr_ram (
    .clk(clk), .we(scr_we), .waddr(step), .wdata(rsp.value),
    .raddr(scr_raddr), .rdata(scr_q)
  );

  always_comb begin
    nd = node_ok ? node_q : '0;
  end

  always_comb begin
    req.op    = nd.op;
    req.a     = a_ok ? qa : '0;
    req.b     = b_ok ? scr_q : '0;
    req.alpha = nd.alpha;
    req.cst   = nd.cst;
    req.err   = ERR_OK;
    case (nd.input_sel)
      2'd0:    req.ldv = val0;
      2'd1:    req.ldv = val1;
      default: req.ldv = val2;
    endcase
    if (nd.op > OP_SIGMOID) begin
      req.err = ERR_OP;
    end else if ((nd.op == OP_LOAD) && ((nd.input_sel >= input_count) ||
                 (nd.input_sel >= MAX_INPUTS) || (nd.input_sel == 2'd3))) begin
      req.err = ERR_LOAD;
    end
  end

  ppi_exec u_exec (.clk(clk), .req(req), .rsp(rsp));

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      node_count  <= 5'd1;
      input_count <= 2'd1;
      node_vld    <= '0;
      scr_vld     <= '0;
      out_valid   <= 1'b0;
      step        <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_NODE_COUNT) node_count <= cfg_data;
        else input_count <= cfg_data[1:0];
      end
      if (node_we) begin
        node_vld[AW'(in_ch.node_index)] <= 1'b1;
      end
      if (scr_we) begin
        scr_vld[step] <= 1'b1;
      end
      if (fin) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          step <= '0;
          if (accept && in_ch.mode) state <= ST_FETCH;
        end
        ST_FETCH: state <= ST_READ;
        ST_READ:  state <= ST_READB;
        ST_READB: state <= ST_EXEC;
        ST_EXEC:  state <= ST_MUL1;
        ST_MUL1:  state <= ST_MUL2;
        ST_MUL2:  state <= ST_WB;
        ST_WB: begin
          if ((rsp.err != ERR_OK) || (step == last_node)) begin
            state <= fin ? ST_IDLE : ST_DONE;
          end else begin
            step  <= step + AW'(1);
            state <= ST_FETCH;
          end
        end
        ST_DONE: begin
          if (fin) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_ch.mode) begin
      val0      <= in_ch.in_value0;
      val1      <= in_ch.in_value1;
      val2      <= in_ch.in_value2;
      last_flag <= in_ch.last_element;
    end
    if (state == ST_FETCH) begin
      node_ok <= node_vld[step];
    end
    if (state == ST_READ) begin
      a_ok <= (nd.src_a < MAX_NODES) && scr_vld[AW'(nd.src_a)];
      b_ok <= (nd.src_b < MAX_NODES) && scr_vld[AW'(nd.src_b)];
    end
    if (state == ST_READB) begin
      qa <= scr_q;
    end
    if (state == ST_WB) begin
      res_err <= rsp.err;
      res_val <= (rsp.err == ERR_OK) ? rsp.value : '0;
    end
    if (fin) begin
      if (state == ST_WB) begin
        out_err   <= rsp.err;
        out_value <= (rsp.err == ERR_OK) ? rsp.value : '0;
      end else begin
        out_err   <= res_err;
        out_value <= res_val;
      end
      out_last <= last_flag;
    end
  end

  assign in_ch.ready       = (state == ST_IDLE);
  assign out_ch.valid      = out_valid;
  assign out_ch.out_value  = out_value;
  assign out_ch.error_code = out_err;
  assign out_ch.out_last   = out_last;
endmodule
`default_nettype wire

// ----- rtl/core/ppi_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module ppi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                          clk,
  input  wire logic                          we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]              wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]              rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- rtl/core/ppi_exec.sv -----
// Three-stage arithmetic unit: sigmoid lookup, operand select, multiply,
// then rounding, saturation and result select. Depends on ppi_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ppi_exec import ppi_pkg::*; (
  input  wire logic      clk,
  input  wire exec_req_t req,
  output exec_rsp_t      rsp
);
  exec_req_t s1;
  q16_t      s1_sig;
  exec_req_t s2;
  q16_t      s2_sig;
  q16_t      s2_mx;
  q16_t      s2_my;
  exec_req_t s3;
  q16_t      s3_sig;
  logic signed [63:0] s3_prod;
  logic signed [63:0] rnd;
  logic signed [63:0] wide_a;

  always_ff @(posedge clk) begin
    s1     <= req;
    s1_sig <= SIG_TABLE[sig_index(req.a)];
    s2     <= s1;
    s2_sig <= s1_sig;
    case (s1.op)
      OP_ADD: begin
        s2_mx <= s1.alpha;
        s2_my <= s1.b;
      end
      OP_MUL: begin
        s2_mx <= s1.a;
        s2_my <= s1.b;
      end
      OP_SILU: begin
        s2_mx <= s1.a;
        s2_my <= s1_sig;
      end
      default: begin
        s2_mx <= s1.alpha;
        s2_my <= s1.a;
      end
    endcase
    s3      <= s2;
    s3_sig  <= s2_sig;
    s3_prod <= 64'(s2_mx) * 64'(s2_my);
  end

  always_comb begin
    rnd = (s3_prod + 64'sd32768) >>> 16;
    wide_a = 64'(s3.a);
    rsp.err = s3.err;
    case (s3.op)
      OP_LOAD:    rsp.value = s3.ldv;
      OP_CONST:   rsp.value = s3.cst;
      OP_ADD:     rsp.value = sat32(wide_a + rnd);
      OP_MUL:     rsp.value = sat32(rnd);
      OP_RELU:    rsp.value = (s3.a > 0) ? s3.a : '0;
      OP_SILU:    rsp.value = sat32(rnd);
      OP_NEG:     rsp.value = sat32(-wide_a);
      OP_SCALE:   rsp.value = sat32(rnd);
      OP_SIGMOID: rsp.value = s3_sig;
      default:    rsp.value = '0;
    endcase
  end
endmodule
`default_nettype wire

// ----- rtl/core/ppi_checker.sv -----
// Port-level checker for the pointwise program interpreter, bound to the top
// level. Depends on ppi_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "pointwise_program_interpreter_unit_macros.svh"
module ppi_checker import ppi_pkg::*; (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       in_mode,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire q16_t       out_value,
  input wire logic [1:0] error_code
);
  `PPI_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)
  `PPI_ASSERT_SAME(a_err_code, clk, rst, out_valid,
    error_code == ERR_OK || error_code == ERR_LOAD || error_code == ERR_OP)
  `PPI_ASSERT_SAME(a_err_zero, clk, rst, out_valid && error_code != ERR_OK,
    out_value == '0)
  `PPI_ASSERT_NEXT(a_busy, clk, rst, in_valid && in_ready && in_mode, !in_ready)
endmodule

bind pointwise_program_interpreter_unit ppi_checker u_ppi_checker (
  .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .in_mode(in_ch.mode), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_value(out_ch.out_value), .error_code(out_ch.error_code)
);
`default_nettype wire
